// ===== src/frp_pkg.sv =====
package frp_pkg;

  localparam int MAX_RECTS = 256;
  localparam int SLOT_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);
  localparam int COORD_W   = 13;
  localparam int SIZE_W    = 14;
  localparam int GAP_W     = 8;
  localparam int POS_W     = 15;
  localparam int INDEX_W   = 8;

  localparam logic [SIZE_W-1:0] ATLAS_LIMIT = 14'd8192;

  typedef enum logic [1:0] {
    STAT_PLACED  = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } status_t;

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_ATLAS_W = 2'd0,
    REG_ATLAS_H = 2'd1,
    REG_BORDER  = 2'd2,
    REG_PADDING = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_t;

  // candidate moving down the cell chain
  typedef struct packed {
    logic               valid;
    rect_t              box;
    logic               hit;
    logic [COORD_W-1:0] hit_w;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    rect_t             box;
  } store_wr_t;

endpackage

// ===== src/frp_cell.sv =====
module frp_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          active,
  input  logic                          wr_en,
  input  frp_pkg::rect_t                wr_box,
  input  logic [frp_pkg::GAP_W-1:0]     pad,
  input  frp_pkg::token_t               tok_in,
  output frp_pkg::token_t               tok_out
);
  import frp_pkg::*;

  rect_t            box;
  logic [COORD_W:0] b_right_pad;
  logic [COORD_W:0] b_bottom_pad;
  logic [COORD_W:0] c_right_pad;
  logic [COORD_W:0] c_bottom_pad;
  logic             clash;
  token_t           tok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box <= wr_box;
    end
  end

  always_comb begin
    b_right_pad  = {1'b0, box.right} + (COORD_W+1)'(pad);
    b_bottom_pad = {1'b0, box.bottom} + (COORD_W+1)'(pad);
    c_right_pad  = {1'b0, tok_in.box.right} + (COORD_W+1)'(pad);
    c_bottom_pad = {1'b0, tok_in.box.bottom} + (COORD_W+1)'(pad);
    // only the first clash along the chain counts
    clash = active && tok_in.valid && !tok_in.hit &&
            ({1'b0, tok_in.box.left} < b_right_pad) &&
            (c_right_pad > {1'b0, box.left}) &&
            ({1'b0, tok_in.box.top} < b_bottom_pad) &&
            (c_bottom_pad > {1'b0, box.top});
    tok = tok_in;
    if (clash) begin
      tok.hit   = 1'b1;
      tok.hit_w = box.right - box.left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok;
    end
  end

endmodule

// ===== src/frp_chain.sv =====
module frp_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [frp_pkg::CNT_W-1:0]   count,
  input  logic [frp_pkg::GAP_W-1:0]   pad,
  input  frp_pkg::store_wr_t          wr,
  input  frp_pkg::token_t             launch_tok,
  output frp_pkg::token_t             exit_tok
);
  import frp_pkg::*;

  token_t               tok [0:MAX_RECTS];
  logic [MAX_RECTS-1:0] vld;

  assign tok[0]   = launch_tok;
  assign exit_tok = tok[MAX_RECTS];

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    logic active;
    logic wr_en;

    assign active = (count > CNT_W'(i));
    assign wr_en  = wr.en && (wr.slot == SLOT_W'(i));
    assign vld[i] = tok[i+1].valid;

    frp_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .active (active),
      .wr_en  (wr_en),
      .wr_box (wr.box),
      .pad    (pad),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) <= 1)
    else $error("more than one candidate in the cell chain");

endmodule

// ===== src/frp_ctrl.sv =====
module frp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [frp_pkg::SIZE_W-1:0]    rect_width,
  input  logic [frp_pkg::SIZE_W-1:0]    rect_height,
  input  logic [frp_pkg::SIZE_W-1:0]    atlas_width,
  input  logic [frp_pkg::SIZE_W-1:0]    atlas_height,
  input  logic [frp_pkg::GAP_W-1:0]     border_width,
  input  logic [frp_pkg::GAP_W-1:0]     padding_gap,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [frp_pkg::COORD_W-1:0]   place_left,
  output logic [frp_pkg::COORD_W-1:0]   place_top,
  output logic [frp_pkg::INDEX_W-1:0]   entry_index,
  output logic [frp_pkg::CNT_W-1:0]     count,
  output frp_pkg::store_wr_t            wr,
  output frp_pkg::token_t               launch_tok,
  input  frp_pkg::token_t               exit_tok
);
  import frp_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count_next;
  logic [POS_W-1:0]    cur_x, cur_x_next;
  logic [SIZE_W-1:0]   cur_y, cur_y_next;
  logic [SIZE_W-1:0]   xlim, xlim_next;
  logic [SIZE_W-1:0]   ylim, ylim_next;
  logic [SIZE_W-1:0]   rw, rw_next;
  logic [SIZE_W-1:0]   rh, rh_next;
  logic                launch, launch_next;
  logic                done_next;
  status_t             status_next;
  logic [COORD_W-1:0]  place_left_next;
  logic [COORD_W-1:0]  place_top_next;
  logic [INDEX_W-1:0]  entry_index_next;

  logic [SIZE_W-1:0]   aw_c;
  logic [SIZE_W-1:0]   ah_c;
  logic [15:0]         xlim_s;
  logic [15:0]         ylim_s;
  logic                fits_x;
  logic                fits_y;
  logic [POS_W-1:0]    nx;
  logic [SIZE_W-1:0]   ny;

  assign busy = (state != ST_IDLE);

  always_comb begin
    launch_tok.valid  = launch;
    launch_tok.box.left   = cur_x[COORD_W-1:0];
    launch_tok.box.top    = cur_y[COORD_W-1:0];
    launch_tok.box.right  = cur_x[COORD_W-1:0] + rw[COORD_W-1:0];
    launch_tok.box.bottom = cur_y[COORD_W-1:0] + rh[COORD_W-1:0];
    launch_tok.hit    = 1'b0;
    launch_tok.hit_w  = '0;
  end

  always_comb begin
    aw_c   = (atlas_width > ATLAS_LIMIT) ? ATLAS_LIMIT : atlas_width;
    ah_c   = (atlas_height > ATLAS_LIMIT) ? ATLAS_LIMIT : atlas_height;
    xlim_s = {2'b00, aw_c} - {2'b00, rect_width} - {8'b0, border_width};
    ylim_s = {2'b00, ah_c} - {2'b00, rect_height} - {8'b0, border_width};
    fits_x = $signed(xlim_s) > $signed({8'b0, border_width});
    fits_y = $signed(ylim_s) > $signed({8'b0, border_width});
    // step right by the clashing box's width plus the padding gap
    nx = cur_x + POS_W'(exit_tok.hit_w) + POS_W'(padding_gap);
    ny = cur_y + SIZE_W'(1);

    state_next       = state;
    count_next       = count;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    xlim_next        = xlim;
    ylim_next        = ylim;
    rw_next          = rw;
    rh_next          = rh;
    launch_next      = 1'b0;
    done_next        = 1'b0;
    status_next      = STAT_PLACED;
    place_left_next  = '0;
    place_top_next   = '0;
    entry_index_next = '0;
    wr               = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (op_t'(op) == OP_CLEAR) begin
            count_next  = '0;
            done_next   = 1'b1;
            status_next = STAT_CLEARED;
          end else if (count >= CNT_W'(MAX_RECTS)) begin
            done_next   = 1'b1;
            status_next = STAT_FULL;
          end else if (rect_width == '0 || rect_height == '0 || !fits_x || !fits_y) begin
            done_next   = 1'b1;
            status_next = STAT_NO_ROOM;
          end else begin
            cur_x_next  = POS_W'(border_width);
            cur_y_next  = SIZE_W'(border_width);
            xlim_next   = xlim_s[SIZE_W-1:0];
            ylim_next   = ylim_s[SIZE_W-1:0];
            rw_next     = rect_width;
            rh_next     = rect_height;
            launch_next = 1'b1;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (exit_tok.valid) begin
          if (!exit_tok.hit) begin
            wr.en            = 1'b1;
            wr.slot          = count[SLOT_W-1:0];
            wr.box           = exit_tok.box;
            count_next       = count + CNT_W'(1);
            done_next        = 1'b1;
            status_next      = STAT_PLACED;
            place_left_next  = exit_tok.box.left;
            place_top_next   = exit_tok.box.top;
            entry_index_next = INDEX_W'(count);
            state_next       = ST_IDLE;
          end else if (nx >= {1'b0, xlim}) begin
            if (ny >= ylim) begin
              done_next   = 1'b1;
              status_next = STAT_NO_ROOM;
              state_next  = ST_IDLE;
            end else begin
              // advance to the next row
              cur_x_next  = POS_W'(border_width);
              cur_y_next  = ny;
              launch_next = 1'b1;
            end
          end else begin
            cur_x_next  = nx;
            launch_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      launch <= launch_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_x       <= cur_x_next;
    cur_y       <= cur_y_next;
    xlim        <= xlim_next;
    ylim        <= ylim_next;
    rw          <= rw_next;
    rh          <= rh_next;
    status      <= status_next;
    place_left  <= place_left_next;
    place_top   <= place_top_next;
    entry_index <= entry_index_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe while scanning");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECTS))
    else $error("store count beyond capacity");

  a_launch_once: assert property (@(posedge clk) disable iff (rst)
    launch |=> !launch)
    else $error("candidate launched on consecutive cycles");

  a_place_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_PLACED) |-> count == CNT_W'($past(count) + 1'b1))
    else $error("placement without store count increment");

  a_wr_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_SCAN && exit_tok.valid))
    else $error("store write outside a scan");

endmodule

// ===== src/first_fit_rect_placer.sv =====
// Channel   Direction  Handshake          Payload
// request   in         start & !busy      op, rect_width, rect_height
// result    out        done (one cycle)   status, place_left, place_top, entry_index
// config    in         APB write          atlas_width, atlas_height, border_width,
//                                         padding_gap at 0x0, 0x4, 0x8, 0xC
//
// Clear, store-full and no-room-up-front requests answer one cycle after start.
// A place request scans candidates; each candidate runs through the chain of
// MAX_RECTS cells, and the result follows in the cycle after the last
// candidate leaves the chain. The candidate count is data dependent.
// Reset (rst, synchronous) empties the store and loads register defaults.
// busy is high during a scan; results cannot be stalled.
module first_fit_rect_placer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [frp_pkg::SIZE_W-1:0]    rect_width,
  input  logic [frp_pkg::SIZE_W-1:0]    rect_height,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [frp_pkg::COORD_W-1:0]   place_left,
  output logic [frp_pkg::COORD_W-1:0]   place_top,
  output logic [frp_pkg::INDEX_W-1:0]   entry_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import frp_pkg::*;

  logic [SIZE_W-1:0] atlas_width;
  logic [SIZE_W-1:0] atlas_height;
  logic [GAP_W-1:0]  border_width;
  logic [GAP_W-1:0]  padding_gap;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic [CNT_W-1:0]  count;
  store_wr_t         wr;
  token_t            launch_tok;
  token_t            exit_tok;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= SIZE_W'(1024);
      atlas_height <= SIZE_W'(1024);
      border_width <= '0;
      padding_gap  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ATLAS_W: atlas_width  <= pwdata[SIZE_W-1:0];
        REG_ATLAS_H: atlas_height <= pwdata[SIZE_W-1:0];
        REG_BORDER:  border_width <= pwdata[GAP_W-1:0];
        REG_PADDING: padding_gap  <= pwdata[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ATLAS_W: prdata = 32'(atlas_width);
      REG_ATLAS_H: prdata = 32'(atlas_height);
      REG_BORDER:  prdata = 32'(border_width);
      REG_PADDING: prdata = 32'(padding_gap);
      default:     prdata = '0;
    endcase
  end

  frp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .op          (op),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .atlas_width (atlas_width),
    .atlas_height(atlas_height),
    .border_width(border_width),
    .padding_gap (padding_gap),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .place_left  (place_left),
    .place_top   (place_top),
    .entry_index (entry_index),
    .count       (count),
    .wr          (wr),
    .launch_tok  (launch_tok),
    .exit_tok    (exit_tok)
  );

  frp_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .count     (count),
    .pad       (padding_gap),
    .wr        (wr),
    .launch_tok(launch_tok),
    .exit_tok  (exit_tok)
  );

endmodule
